// ===== sv/rtg_pkg.sv =====
// ----------------------------------------------------------------------------
// rtg_pkg
// Shared types, constants and lookup tables of the rotozoom texel generator.
// ----------------------------------------------------------------------------
`default_nettype none

package rtg_pkg;

  // Texture geometry and coordinate format
  localparam int TEX_BITS    = 4;
  localparam int TEX_ENTRIES = 256;
  localparam int FRAC_SHIFT  = 18;
  localparam int SINE_BITS   = 6;
  localparam logic [SINE_BITS-1:0] QUARTER_TURN = 6'd16;
  localparam logic [6:0] MAX_DIM = 7'd64;

  // Request codes
  localparam logic OP_PIXEL       = 1'b0;
  localparam logic OP_TEXEL_WRITE = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_ZOOM_BIAS    = 2'd2;

  // Configuration reset values
  localparam logic [6:0] RST_FRAME_WIDTH  = 7'd40;
  localparam logic [6:0] RST_FRAME_HEIGHT = 7'd40;
  localparam logic [9:0] RST_ZOOM_BIAS    = 10'd400;

  // Request and result queue depth
  localparam logic [1:0] QUEUE_DEPTH = 2'd2;

  typedef struct packed {
    logic       is_write;
    logic [7:0] addr;
    logic [2:0] value;
  } item_t;

  typedef struct packed {
    logic [2:0] color;
    logic       same;
    logic       line_end;
    logic       frame_end;
  } res_t;

  typedef struct packed {
    logic [6:0] frame_width;
    logic [6:0] frame_height;
    logic [9:0] zoom_bias;
  } cfg_t;

  // Built-in logo, one nibble per texel, column 0 in the top nibble
  localparam logic [63:0] LOGO_ROWS [16] = '{
    64'h7777_7753_3333_3337,
    64'h7777_7775_3333_3337,
    64'h1111_2777_3333_3337,
    64'h0000_0177_5333_3337,
    64'h0000_0077_6333_3367,
    64'h0000_0077_5333_3477,
    64'h0000_0277_4333_3777,
    64'h0222_7776_3333_6777,
    64'h0777_7763_3335_7727,
    64'h0177_7433_3337_7707,
    64'h0027_7633_3367_7107,
    64'h0002_7753_3577_2007,
    64'h0000_7775_4772_0007,
    64'h0000_0777_7770_0007,
    64'h0000_0177_7710_0007,
    64'h7777_7777_7777_7777
  };

  // Sine scaled to 256, one full turn
  localparam logic signed [9:0] SINE_ROM [64] = '{
    10'sd0,    10'sd25,   10'sd49,   10'sd74,   10'sd97,   10'sd120,  10'sd142,  10'sd162,
    10'sd181,  10'sd197,  10'sd212,  10'sd225,  10'sd236,  10'sd244,  10'sd251,  10'sd254,
    10'sd256,  10'sd254,  10'sd251,  10'sd244,  10'sd236,  10'sd225,  10'sd212,  10'sd197,
    10'sd181,  10'sd162,  10'sd142,  10'sd120,  10'sd97,   10'sd74,   10'sd49,   10'sd25,
    10'sd0,    -10'sd25,  -10'sd49,  -10'sd74,  -10'sd97,  -10'sd120, -10'sd142, -10'sd162,
    -10'sd181, -10'sd197, -10'sd212, -10'sd225, -10'sd236, -10'sd244, -10'sd251, -10'sd254,
    -10'sd256, -10'sd254, -10'sd251, -10'sd244, -10'sd236, -10'sd225, -10'sd212, -10'sd197,
    -10'sd181, -10'sd162, -10'sd142, -10'sd120, -10'sd97,  -10'sd74,  -10'sd49,  -10'sd25
  };

  // Reset image texel at a texture address (row in the upper half)
  function automatic logic [2:0] logo_texel(input logic [7:0] addr);
    logic [63:0] row_bits;
    logic [5:0]  lsb;
    row_bits = LOGO_ROWS[addr[7:4]];
    lsb      = {~addr[3:0], 2'b00};
    return row_bits[lsb +: 3];
  endfunction

  // Force a frame dimension into 1..64
  function automatic logic [6:0] clamp_dim(input logic [6:0] v);
    logic [6:0] r;
    if (v == 7'd0) begin
      r = 7'd1;
    end else if (v > MAX_DIM) begin
      r = MAX_DIM;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/rtg_front.sv =====
// ----------------------------------------------------------------------------
// rtg_front
// Input side: accepts requests, decodes them and holds them in a short queue
// for the pixel sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module rtg_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_push,
  output logic                in_full,
  input  wire logic           in_operation,
  input  wire logic [7:0]     in_texel_address,
  input  wire logic [2:0]     in_texel_value,
  input  wire logic           item_pop,
  output logic                item_empty,
  output rtg_pkg::item_t      item
);

  logic [1:0]     count_r, count_nxt;
  logic           wr_ptr_r, rd_ptr_r;
  rtg_pkg::item_t slot_r [2];
  rtg_pkg::item_t decoded;
  logic           do_push, do_pop;

  // Decode the incoming request
  always_comb begin
    decoded.is_write = (in_operation == rtg_pkg::OP_TEXEL_WRITE);
    decoded.addr     = in_texel_address;
    decoded.value    = in_texel_value;
  end

  assign in_full    = (count_r == rtg_pkg::QUEUE_DEPTH);
  assign item_empty = (count_r == 2'd0);
  assign item       = slot_r[rd_ptr_r];
  assign do_push    = in_push && !in_full;
  assign do_pop     = item_pop && !item_empty;
  assign count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  // Store the decoded request
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= decoded;
    end
  end

endmodule

`default_nettype wire

// ===== sv/rtg_back.sv =====
// ----------------------------------------------------------------------------
// rtg_back
// Pixel sequencer: owns the texture memory, the raster position and the
// affine coordinates, runs the frame setup multiplies and emits results.
// ----------------------------------------------------------------------------
`default_nettype none

module rtg_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire rtg_pkg::cfg_t  cfg,
  input  wire rtg_pkg::item_t item,
  input  wire logic           item_empty,
  output logic                item_pop,
  input  wire logic           res_full,
  output logic                res_push,
  output rtg_pkg::res_t       res
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_STEP = 5'b00010,
    ST_ORIG = 5'b00100,
    ST_READ = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t      state_r, state_nxt;
  logic [5:0]  column_r, row_r, frame_r;
  logic [31:0] step_x_r, step_y_r, rsx_r, rsy_r, cx_r, cy_r;
  logic        last_vld_r;
  logic [2:0]  last_color_r;

  // Texture store with per-entry written flags over the logo image
  logic [2:0]   tex_mem [rtg_pkg::TEX_ENTRIES];
  logic [255:0] tex_vld_r;
  logic [2:0]   rd_data_r, logo_r;
  logic         rd_vld_r;
  logic [7:0]   rd_addr;
  logic         tex_we;

  // Setup datapath
  logic signed [9:0]  s0, s1;
  logic signed [11:0] biased;
  logic signed [12:0] scale;
  logic signed [22:0] prod_x, prod_y;
  logic [5:0]         half_w, half_h;
  logic [31:0]        org_x_prod, org_y_prod;

  // Emit datapath
  logic [6:0] dim_w, dim_h;
  logic [2:0] color;
  logic       lend, fend, emit_fire;

  assign dim_w = rtg_pkg::clamp_dim(cfg.frame_width);
  assign dim_h = rtg_pkg::clamp_dim(cfg.frame_height);

  assign rd_addr = {cy_r[rtg_pkg::FRAC_SHIFT +: rtg_pkg::TEX_BITS],
                    cx_r[rtg_pkg::FRAC_SHIFT +: rtg_pkg::TEX_BITS]};
  assign item_pop = (state_r == ST_IDLE) && !item_empty;
  assign tex_we   = item_pop && item.is_write;

  // Scale and step vector of the frame
  always_comb begin
    s0     = rtg_pkg::SINE_ROM[frame_r];
    s1     = rtg_pkg::SINE_ROM[frame_r + rtg_pkg::QUARTER_TURN];
    biased = {{2{s0[9]}}, s0} + $signed({2'b00, cfg.zoom_bias});
    scale  = {biased, 1'b0};
    prod_x = scale * s0;
    prod_y = scale * s1;
  end

  // Frame origin from the steps
  always_comb begin
    half_w     = dim_w[6:1];
    half_h     = dim_h[6:1];
    org_x_prod = (step_x_r - step_y_r) * {26'd0, half_w};
    org_y_prod = (step_y_r + step_x_r) * {26'd0, half_h};
  end

  // Result of the current pixel
  always_comb begin
    color         = rd_vld_r ? rd_data_r : logo_r;
    lend          = ({1'b0, column_r} + 7'd1 >= dim_w);
    fend          = lend && ({1'b0, row_r} + 7'd1 >= dim_h);
    emit_fire     = (state_r == ST_EMIT) && !res_full;
    res_push      = emit_fire;
    res.color     = color;
    res.same      = last_vld_r && (last_color_r == color);
    res.line_end  = lend;
    res.frame_end = fend;
  end

  // Sequence each request
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (item_pop && !item.is_write) begin
          if ((column_r == 6'd0) && (row_r == 6'd0)) begin
            state_nxt = ST_STEP;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_STEP: state_nxt = ST_ORIG;
      ST_ORIG: state_nxt = ST_READ;
      ST_READ: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (!res_full) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold the state and the raster position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      column_r   <= 6'd0;
      row_r      <= 6'd0;
      frame_r    <= 6'd0;
      last_vld_r <= 1'b0;
      tex_vld_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (tex_we) begin
        tex_vld_r[item.addr] <= 1'b1;
      end
      if (emit_fire) begin
        last_vld_r <= !lend;
        if (lend) begin
          column_r <= 6'd0;
          if (fend) begin
            row_r   <= 6'd0;
            frame_r <= frame_r + 6'd1;
          end else begin
            row_r <= row_r + 6'd1;
          end
        end else begin
          column_r <= column_r + 6'd1;
        end
      end
    end
  end

  // Advance the coordinates
  always_ff @(posedge clk) begin
    if (state_r == ST_STEP) begin
      step_x_r <= {{9{prod_x[22]}}, prod_x};
      step_y_r <= {{9{prod_y[22]}}, prod_y};
    end
    if (state_r == ST_ORIG) begin
      rsx_r <= 32'd0 - org_x_prod;
      rsy_r <= 32'd0 - org_y_prod;
      cx_r  <= 32'd0 - org_x_prod;
      cy_r  <= 32'd0 - org_y_prod;
    end
    if (emit_fire) begin
      last_color_r <= color;
      if (lend) begin
        rsx_r <= rsx_r - step_y_r;
        rsy_r <= rsy_r + step_x_r;
        cx_r  <= rsx_r - step_y_r;
        cy_r  <= rsy_r + step_x_r;
      end else begin
        cx_r <= cx_r + step_x_r;
        cy_r <= cy_r + step_y_r;
      end
    end
  end

  // Texture memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (tex_we) begin
      tex_mem[item.addr] <= item.value;
    end
    rd_data_r <= tex_mem[rd_addr];
  end

  // Written flag and logo texel at the read address
  always_ff @(posedge clk) begin
    rd_vld_r <= tex_vld_r[rd_addr];
    logo_r   <= rtg_pkg::logo_texel(rd_addr);
  end

endmodule

`default_nettype wire

// ===== sv/rtg_outq.sv =====
// ----------------------------------------------------------------------------
// rtg_outq
// Result side: a short queue that holds finished pixels until they are popped.
// ----------------------------------------------------------------------------
`default_nettype none

module rtg_outq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          res_push,
  input  wire rtg_pkg::res_t res,
  output logic               res_full,
  input  wire logic          out_pop,
  output logic               out_empty,
  output rtg_pkg::res_t      head
);

  logic [1:0]    count_r, count_nxt;
  logic          wr_ptr_r, rd_ptr_r;
  rtg_pkg::res_t slot_r [2];
  logic          do_push, do_pop;

  assign res_full  = (count_r == rtg_pkg::QUEUE_DEPTH);
  assign out_empty = (count_r == 2'd0);
  assign head      = slot_r[rd_ptr_r];
  assign do_push   = res_push && !res_full;
  assign do_pop    = out_pop && !out_empty;
  assign count_nxt = count_r + {1'b0, do_push} - {1'b0, do_pop};

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  // Store the finished pixel
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= res;
    end
  end

endmodule

`default_nettype wire

// ===== sv/rotozoom_texel_generator.sv =====
// ----------------------------------------------------------------------------
// rotozoom_texel_generator
// Rotating and zooming texture mapper producing one color index per pixel.
// ----------------------------------------------------------------------------
// Each pixel request returns the color of the next raster pixel, looked up in a
// 16x16 texture through 32-bit affine coordinates; a texel write request
// replaces one texture entry and returns nothing. Both sides are queues. A
// write is taken by the back-end sequencer without leaving its idle state. A
// pixel is read through the texture memory's registered read port; for the
// first pixel of each frame the sequencer first runs the scale and origin
// multiplies and then reads the texture at the new origin in three extra steps.
// A two-entry request queue and a two-entry result queue let either side stall
// without stopping the other. Configuration writes are always accepted and
// must only be made while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module rotozoom_texel_generator (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  output logic            in_full,
  input  wire logic       in_operation,
  input  wire logic [7:0] in_texel_address,
  input  wire logic [2:0] in_texel_value,
  output logic            out_empty,
  input  wire logic       out_pop,
  output logic [2:0]      out_color_index,
  output logic            out_same_as_previous,
  output logic            out_line_end,
  output logic            out_frame_end,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [9:0] cfg_data
);

  rtg_pkg::cfg_t  cfg_r;
  rtg_pkg::item_t item;
  rtg_pkg::res_t  res, head;
  logic           item_pop, item_empty, res_push, res_full;

  assign cfg_ready = 1'b1;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width  <= rtg_pkg::RST_FRAME_WIDTH;
      cfg_r.frame_height <= rtg_pkg::RST_FRAME_HEIGHT;
      cfg_r.zoom_bias    <= rtg_pkg::RST_ZOOM_BIAS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rtg_pkg::REG_FRAME_WIDTH:  cfg_r.frame_width  <= cfg_data[6:0];
        rtg_pkg::REG_FRAME_HEIGHT: cfg_r.frame_height <= cfg_data[6:0];
        rtg_pkg::REG_ZOOM_BIAS:    cfg_r.zoom_bias    <= cfg_data;
        default: ;
      endcase
    end
  end

  rtg_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_operation     (in_operation),
    .in_texel_address (in_texel_address),
    .in_texel_value   (in_texel_value),
    .item_pop         (item_pop),
    .item_empty       (item_empty),
    .item             (item)
  );

  rtg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item       (item),
    .item_empty (item_empty),
    .item_pop   (item_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res)
  );

  rtg_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .head      (head)
  );

  assign out_color_index      = head.color;
  assign out_same_as_previous = head.same;
  assign out_line_end         = head.line_end;
  assign out_frame_end        = head.frame_end;

  // Sequencer never emits into a full result queue
  a_no_res_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  // Sequencer only pops a waiting request
  a_no_item_underflow : assert property (@(posedge clk) disable iff (!rst_n)
    item_pop |-> !item_empty)
    else $error("request popped from an empty queue");

  // Frame end only on the last pixel of a row
  a_frame_end_is_line_end : assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (!out_frame_end || out_line_end))
    else $error("frame end without line end");

endmodule

`default_nettype wire
